>>> design/assert_macros.svh
// Assertion macros for the smoother RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational or implication property checked on every clock edge out of reset.
`define CGFS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");

// Antecedent in one cycle implies consequent in the next.
`define CGFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

>>> design/cgfs_pkg.sv
// Shared constants and controller/datapath interface types for the FIR smoother.
package cgfs_pkg;

  localparam int unsigned MaxHalfWidth = 15;
  localparam int unsigned SampleBits   = 16;
  localparam int unsigned WeightBits   = 16;
  localparam int unsigned WinLen       = 2 * MaxHalfWidth + 1;
  localparam int unsigned HwBits       = 4;
  localparam int unsigned PosBits      = $clog2(WinLen);
  localparam int unsigned SeenBits     = $clog2(WinLen + 1);
  localparam int unsigned ProdBits     = SampleBits + WeightBits + 1;
  localparam int unsigned AccBits      = ProdBits + $clog2(WinLen);
  localparam int unsigned CfgIdxBits   = 3;
  localparam int unsigned CfgDataBits  = 64;
  localparam int unsigned LanesPerReg  = CfgDataBits / WeightBits;
  localparam int unsigned NumWeightReg = (MaxHalfWidth + 1) / LanesPerReg;

  localparam logic [CfgIdxBits-1:0] CfgHalfWidth = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgWeights0  = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgWeights1  = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgWeights2  = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgWeights3  = 3'd4;

  typedef struct packed {
    logic               shift;
    logic               clr_acc;
    logic               issue;
    logic               load_out;
    logic               last_out;
    logic               clear_win;
    logic [HwBits-1:0]  p;
    logic [PosBits-1:0] tap;
  } cmd_t;

  typedef struct packed {
    logic [SeenBits-1:0] seen;
    logic [HwBits-1:0]   hw;
    logic                last;
    logic                out_free;
  } status_t;

endpackage

>>> design/cgfs_datapath.sv
// Datapath: config registers, sample window, serial MAC, rounding and output register.
module cgfs_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cgfs_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [cgfs_pkg::CfgDataBits-1:0]  cfg_data_i,
  input  logic [cgfs_pkg::SampleBits-1:0]   s_axis_tdata_i,  // [15:0] sample
  input  logic                              s_axis_tlast_i,
  output logic [cgfs_pkg::SampleBits-1:0]   m_axis_tdata_o,  // [15:0] smoothed
  output logic                              m_axis_tlast_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  input  cgfs_pkg::cmd_t                    cmd_i,
  output cgfs_pkg::status_t                 status_o
);

  localparam int unsigned SB = cgfs_pkg::SampleBits;
  localparam int unsigned WB = cgfs_pkg::WeightBits;
  localparam int unsigned AB = cgfs_pkg::AccBits;
  localparam int unsigned PB = cgfs_pkg::ProdBits;
  localparam int unsigned QB = AB - WB;

  logic [cgfs_pkg::HwBits-1:0]      hw_q;
  logic [cgfs_pkg::CfgDataBits-1:0] wreg_q [cgfs_pkg::NumWeightReg];
  logic signed [SB-1:0]             win_q [cgfs_pkg::WinLen];
  logic [cgfs_pkg::SeenBits-1:0]    seen_q;
  logic                             last_q;
  logic signed [PB-1:0]             prod_q;
  logic                             prod_vld_q;
  logic signed [AB-1:0]             acc_q;
  logic [SB-1:0]                    out_q;
  logic                             out_last_q;
  logic                             out_vld_q;

  // Tap operand selection
  logic signed [cgfs_pkg::PosBits+1:0] pos;
  logic signed [cgfs_pkg::PosBits:0]   tap_ofs;
  logic [cgfs_pkg::HwBits-1:0]         off;
  logic signed [SB-1:0]                smp;
  logic [WB-1:0]                       wgt;
  logic [cgfs_pkg::CfgDataBits-1:0]    wsel;
  logic signed [PB-1:0]                prod_d;

  always_comb begin
    pos  = $signed({3'b000, cmd_i.p}) + $signed({3'b000, hw_q})
         - $signed({2'b00, cmd_i.tap});
    tap_ofs = $signed({1'b0, cmd_i.tap}) - $signed({2'b00, hw_q});
    off  = tap_ofs[cgfs_pkg::PosBits] ? cgfs_pkg::HwBits'(-tap_ofs)
                                      : cgfs_pkg::HwBits'(tap_ofs);
    smp  = pos[cgfs_pkg::PosBits+1] ? '0 : win_q[pos[cgfs_pkg::PosBits-1:0]];
    wsel = wreg_q[off[cgfs_pkg::HwBits-1:2]];
    wgt  = wsel[off[1:0]*WB +: WB];
    prod_d = PB'(smp * $signed({1'b0, wgt}));
  end

  // Round half up, then saturate
  logic signed [AB-1:0] rnd;
  logic signed [QB-1:0] quo;
  logic [SB-1:0]        res;

  always_comb begin
    rnd = acc_q + $signed(AB'(1) << (WB - 1));
    quo = QB'(rnd >>> WB);
    if (quo > $signed(QB'((1 << (SB - 1)) - 1))) begin
      res = {1'b0, {(SB-1){1'b1}}};
    end else if (quo < -$signed(QB'(1 << (SB - 1)))) begin
      res = {1'b1, {(SB-1){1'b0}}};
    end else begin
      res = quo[SB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= '0;
      for (int i = 0; i < cgfs_pkg::NumWeightReg; i++) begin
        wreg_q[i] <= '0;
      end
      wreg_q[0] <= cgfs_pkg::CfgDataBits'({WB{1'b1}});
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cgfs_pkg::CfgHalfWidth: hw_q      <= cfg_data_i[cgfs_pkg::HwBits-1:0];
        cgfs_pkg::CfgWeights0:  wreg_q[0] <= cfg_data_i;
        cgfs_pkg::CfgWeights1:  wreg_q[1] <= cfg_data_i;
        cgfs_pkg::CfgWeights2:  wreg_q[2] <= cfg_data_i;
        cgfs_pkg::CfgWeights3:  wreg_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cgfs_pkg::WinLen; i++) begin
        win_q[i] <= '0;
      end
      seen_q <= '0;
      last_q <= 1'b0;
    end else if (cmd_i.clear_win) begin
      for (int i = 0; i < cgfs_pkg::WinLen; i++) begin
        win_q[i] <= '0;
      end
      seen_q <= '0;
    end else if (cmd_i.shift) begin
      for (int i = cgfs_pkg::WinLen - 1; i > 0; i--) begin
        win_q[i] <= win_q[i-1];
      end
      win_q[0] <= s_axis_tdata_i;
      if (seen_q != cgfs_pkg::SeenBits'(cgfs_pkg::WinLen)) begin
        seen_q <= seen_q + 1'b1;
      end
      last_q <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= cmd_i.issue;
      if (cmd_i.clr_acc) begin
        acc_q <= '0;
      end else if (prod_vld_q) begin
        acc_q <= acc_q + AB'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q      <= res;
      out_last_q <= cmd_i.last_out;
    end
  end

  assign m_axis_tdata_o  = out_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tvalid_o = out_vld_q;

  assign status_o.seen     = seen_q;
  assign status_o.hw       = hw_q;
  assign status_o.last     = last_q;
  assign status_o.out_free = !out_vld_q || m_axis_tready_i;

endmodule

>>> design/cgfs_ctrl.sv
// Controller FSM: sequences window update, MAC passes, result emission and end-of-set flush.
`include "assert_macros.svh"

module cgfs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  cgfs_pkg::status_t status_i,
  output cgfs_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StDecide = 3'd1;
  localparam logic [2:0] StMac    = 3'd2;
  localparam logic [2:0] StDrain  = 3'd3;
  localparam logic [2:0] StEmit   = 3'd4;

  logic [2:0]                     state_q, state_d;
  logic [cgfs_pkg::HwBits-1:0]    p_q, p_d;
  logic [cgfs_pkg::PosBits-1:0]   tap_q, tap_d;
  logic                           tap_last;

  assign tap_last = (tap_q == {status_i.hw, 1'b0});

  always_comb begin
    state_d         = state_q;
    p_d             = p_q;
    tap_d           = tap_q;
    s_axis_tready_o = 1'b0;
    cmd_o           = '0;
    cmd_o.p         = p_q;
    cmd_o.tap       = tap_q;
    unique case (state_q)
      StIdle: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cmd_o.shift = 1'b1;
          state_d     = StDecide;
        end
      end
      StDecide: begin
        cmd_o.clr_acc = 1'b1;
        tap_d         = '0;
        if (status_i.seen > cgfs_pkg::SeenBits'(status_i.hw)) begin
          p_d     = status_i.hw;
          state_d = StMac;
        end else if (status_i.last) begin
          p_d     = status_i.seen[cgfs_pkg::HwBits-1:0] - 1'b1;
          state_d = StMac;
        end else begin
          state_d = StIdle;
        end
      end
      StMac: begin
        cmd_o.issue = 1'b1;
        tap_d       = tap_q + 1'b1;
        if (tap_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StEmit;
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.last_out = status_i.last && (p_q == '0);
          if (status_i.last && (p_q != '0)) begin
            p_d           = p_q - 1'b1;
            cmd_o.clr_acc = 1'b1;
            tap_d         = '0;
            state_d       = StMac;
          end else begin
            cmd_o.clear_win = status_i.last;
            state_d         = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      p_q     <= '0;
      tap_q   <= '0;
    end else begin
      state_q <= state_d;
      p_q     <= p_d;
      tap_q   <= tap_d;
    end
  end

  `CGFS_ASSERT(a_load_only_when_free, !cmd_o.load_out || status_i.out_free)
  `CGFS_ASSERT(a_tap_in_kernel, !cmd_o.issue || (tap_q <= {status_i.hw, 1'b0}))
  `CGFS_ASSERT_NEXT(a_accept_to_decide, s_axis_tvalid_i && s_axis_tready_o, state_q == StDecide)
  `CGFS_ASSERT(a_flush_pos_in_range, (state_q != StMac) || (p_q <= status_i.hw))

endmodule

>>> design/centered_gaussian_fir_smoother.sv
// After a request is accepted the controller decides whether a result is due; if so it runs a
// MAC pass over the kernel taps, drains, and emits once the output register is free, taking no
// new request before then; on the last of a set, each further flushed result adds a MAC pass.
// The output register lets the next sample enter while a result waits to be taken.
// Reset (rst_ni low, asynchronous): window and counts cleared, half_width 0,
// offset-0 weight 65535 and all other weights 0.
module centered_gaussian_fir_smoother (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cgfs_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [cgfs_pkg::CfgDataBits-1:0]  cfg_data_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [cgfs_pkg::SampleBits-1:0]   s_axis_tdata_i,  // [15:0] sample
  input  logic                              s_axis_tlast_i,  // last_in
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [cgfs_pkg::SampleBits-1:0]   m_axis_tdata_o,  // [15:0] smoothed
  output logic                              m_axis_tlast_o   // last_out
);

  cgfs_pkg::cmd_t    cmd;
  cgfs_pkg::status_t status;

  cgfs_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  cgfs_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cmd_i           (cmd),
    .status_o        (status)
  );

endmodule
